// ===== hw/rtl/rhi_pkg.sv =====
// ----------------------------------------------------------------------------
// rhi_pkg: shared constants, types and tables
// Fixed-point widths, angle constants, CORDIC arctangent table and the
// status codes of the ray heading intersection pipeline.
// ----------------------------------------------------------------------------
package rhi_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 16;

    localparam int HEAD_W   = 24;
    localparam int POS_W    = 32;
    localparam int DIFF_W   = POS_W + 1;
    localparam int QEST_W   = 24;
    localparam int RED_W    = 36;
    localparam int ANG_W    = 34;
    localparam int TRIG_W   = 32;
    localparam int DET_W    = 36;
    localparam int NUM_W    = 66;
    localparam int DMAG_W   = 35;
    localparam int QUO_W    = 36;
    localparam int CMP_W    = DMAG_W + QUO_W;

    localparam int SC_LAT   = CORDIC_STEPS + 5;
    localparam int GEOM_LAT = 2;
    localparam int DIV_LAT  = QUO_W + 1;

    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint CORDIC_K    = 64'sd652032874;
    localparam longint S_LIMIT     = 64'sd17179869184;

    localparam longint REC_SHIFT = 34;
    localparam longint REC_TURN  =
        ((longint'(1) << (64 - FRAC_BITS)) + TWO_PI_Q30 / 2) / TWO_PI_Q30;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PARALLEL  = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic             big;
        logic [QUO_W-1:0] quo;
    } div_out_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            0:  val = ANG_W'(843314857);
            1:  val = ANG_W'(497837829);
            2:  val = ANG_W'(263043837);
            3:  val = ANG_W'(133525159);
            4:  val = ANG_W'(67021687);
            5:  val = ANG_W'(33543516);
            6:  val = ANG_W'(16775851);
            7:  val = ANG_W'(8388437);
            8:  val = ANG_W'(4194283);
            9:  val = ANG_W'(2097151);
            10: val = ANG_W'(1048576);
            11: val = ANG_W'(524288);
            12: val = ANG_W'(262144);
            13: val = ANG_W'(131072);
            14: val = ANG_W'(65536);
            15: val = ANG_W'(32768);
            16: val = ANG_W'(16384);
            17: val = ANG_W'(8192);
            18: val = ANG_W'(4096);
            19: val = ANG_W'(2048);
            20: val = ANG_W'(1024);
            21: val = ANG_W'(512);
            22: val = ANG_W'(256);
            23: val = ANG_W'(128);
            24: val = ANG_W'(64);
            25: val = ANG_W'(32);
            26: val = ANG_W'(16);
            27: val = ANG_W'(8);
            28: val = ANG_W'(4);
            29: val = ANG_W'(2);
            30: val = ANG_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/rhi_sincos.sv =====
// ----------------------------------------------------------------------------
// rhi_sincos: heading to cosine and sine
// Reduces a heading to (-pi, pi], folds it into [-pi/2, pi/2] and runs one
// CORDIC iteration per pipeline stage. Outputs are Q28.
// ----------------------------------------------------------------------------
module rhi_sincos
    import rhi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [HEAD_W-1:0] heading,
    output logic                     out_valid,
    output logic signed [TRIG_W-1:0] cos_q28,
    output logic signed [TRIG_W-1:0] sin_q28
);

    localparam logic signed [63:0]      REC_S    = 64'(REC_TURN);
    localparam logic signed [63:0]      TWO_PI_S = 64'(TWO_PI_Q30);
    localparam logic signed [RED_W-1:0] TWO_PI_R = RED_W'(TWO_PI_Q30);
    localparam logic signed [RED_W-1:0] PI_R     = RED_W'(PI_Q30);
    localparam logic signed [RED_W-1:0] HPI_R    = RED_W'(HALF_PI_Q30);
    localparam logic signed [RED_W-1:0] NPI_R    = -RED_W'(PI_Q30);
    localparam logic signed [RED_W-1:0] NHPI_R   = -RED_W'(HALF_PI_Q30);

    logic                     vld_reg [SC_LAT];

    logic signed [HEAD_W-1:0] head_a_reg;
    logic signed [QEST_W-1:0] q_a_reg;
    logic signed [RED_W-1:0]  r_b_reg;
    logic signed [RED_W-1:0]  r_c_reg;
    logic signed [ANG_W-1:0]  z_d_reg;
    logic                     neg_d_reg;

    logic signed [ANG_W-1:0]  cx_reg  [CORDIC_STEPS];
    logic signed [ANG_W-1:0]  cy_reg  [CORDIC_STEPS];
    logic signed [ANG_W-1:0]  cz_reg  [CORDIC_STEPS];
    logic                     cneg_reg[CORDIC_STEPS];

    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    logic signed [63:0]       q_prod;
    logic signed [QEST_W-1:0] q_next;
    logic signed [63:0]       ang_b;
    logic signed [63:0]       red_b;
    logic signed [RED_W-1:0]  r_c_next;
    logic signed [RED_W-1:0]  r_d_fold;
    logic                     neg_d_next;
    logic signed [ANG_W-1:0]  ex_x;
    logic signed [ANG_W-1:0]  ex_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SC_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < SC_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // estimate turn count
    always_comb
    begin
        q_prod = 64'(heading) * REC_S + (64'sd1 <<< (REC_SHIFT - 1));
        q_next = QEST_W'(q_prod >>> REC_SHIFT);
    end

    always_comb
    begin
        ang_b = 64'(head_a_reg) <<< (30 - FRAC_BITS);
        red_b = ang_b - 64'(q_a_reg) * TWO_PI_S;
    end

    always_comb
    begin
        if (r_b_reg > PI_R)
        begin
            r_c_next = r_b_reg - TWO_PI_R;
        end
        else if (r_b_reg <= NPI_R)
        begin
            r_c_next = r_b_reg + TWO_PI_R;
        end
        else
        begin
            r_c_next = r_b_reg;
        end
    end

    always_comb
    begin
        if (r_c_reg > HPI_R)
        begin
            r_d_fold   = r_c_reg - PI_R;
            neg_d_next = 1'b1;
        end
        else if (r_c_reg < NHPI_R)
        begin
            r_d_fold   = r_c_reg + PI_R;
            neg_d_next = 1'b1;
        end
        else
        begin
            r_d_fold   = r_c_reg;
            neg_d_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        head_a_reg <= heading;
        q_a_reg    <= q_next;
        r_b_reg    <= RED_W'(red_b);
        r_c_reg    <= r_c_next;
        z_d_reg    <= ANG_W'(r_d_fold);
        neg_d_reg  <= neg_d_next;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [ANG_W-1:0] x_in;
        logic signed [ANG_W-1:0] y_in;
        logic signed [ANG_W-1:0] z_in;
        logic                    neg_in;
        if (i == 0)
        begin : g_first
            assign x_in   = ANG_W'(CORDIC_K);
            assign y_in   = '0;
            assign z_in   = z_d_reg;
            assign neg_in = neg_d_reg;
        end
        else
        begin : g_next
            assign x_in   = cx_reg[i-1];
            assign y_in   = cy_reg[i-1];
            assign z_in   = cz_reg[i-1];
            assign neg_in = cneg_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (!z_in[ANG_W-1])
            begin
                cx_reg[i] <= x_in - (y_in >>> i);
                cy_reg[i] <= y_in + (x_in >>> i);
                cz_reg[i] <= z_in - atan_q30(i);
            end
            else
            begin
                cx_reg[i] <= x_in + (y_in >>> i);
                cy_reg[i] <= y_in - (x_in >>> i);
                cz_reg[i] <= z_in + atan_q30(i);
            end
            cneg_reg[i] <= neg_in;
        end
    end

    // flip sign for folded angles
    always_comb
    begin
        ex_x = cneg_reg[CORDIC_STEPS-1] ? -cx_reg[CORDIC_STEPS-1] : cx_reg[CORDIC_STEPS-1];
        ex_y = cneg_reg[CORDIC_STEPS-1] ? -cy_reg[CORDIC_STEPS-1] : cy_reg[CORDIC_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= TRIG_W'(ex_x >>> 2);
        sin_reg <= TRIG_W'(ex_y >>> 2);
    end

    assign out_valid = vld_reg[SC_LAT-1];
    assign cos_q28   = cos_reg;
    assign sin_q28   = sin_reg;

endmodule

// ===== hw/rtl/rhi_geom.sv =====
// ----------------------------------------------------------------------------
// rhi_geom: determinant and numerator
// Forms the cross products of the two direction vectors and of the point
// offset, in two register stages.
// ----------------------------------------------------------------------------
module rhi_geom
    import rhi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [TRIG_W-1:0] c1,
    input  logic signed [TRIG_W-1:0] s1,
    input  logic signed [TRIG_W-1:0] c2,
    input  logic signed [TRIG_W-1:0] s2,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    output logic                     out_valid,
    output logic signed [NUM_W-1:0]  num,
    output logic signed [DET_W-1:0]  det,
    output logic                     parallel
);

    logic                      v1_reg;
    logic                      v2_reg;
    logic signed [63:0]        p1_reg;
    logic signed [63:0]        p2_reg;
    logic signed [64:0]        m1_reg;
    logic signed [64:0]        m2_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic signed [DET_W-1:0]   det_reg;
    logic                      par_reg;

    logic signed [64:0]        diff;
    logic signed [DET_W-1:0]   det_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        diff     = 65'(p1_reg) - 65'(p2_reg);
        det_next = DET_W'(diff >>> 28);
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= 64'(s1) * 64'(c2);
        p2_reg  <= 64'(c1) * 64'(s2);
        m1_reg  <= 65'(dx) * 65'(s2);
        m2_reg  <= 65'(dy) * 65'(c2);
        num_reg <= NUM_W'(m1_reg) - NUM_W'(m2_reg);
        det_reg <= det_next;
        par_reg <= (det_next == '0);
    end

    assign out_valid = v2_reg;
    assign num       = num_reg;
    assign det       = det_reg;
    assign parallel  = par_reg;

endmodule

// ===== hw/rtl/rhi_divide.sv =====
// ----------------------------------------------------------------------------
// rhi_divide: pipelined restoring divider
// Divides the numerator magnitude by the determinant magnitude, one quotient
// bit per stage, and flags quotients too large for the quotient width.
// ----------------------------------------------------------------------------
module rhi_divide
    import rhi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DET_W-1:0] det,
    output div_out_t                res
);

    logic              vld_reg  [QUO_W+1];
    logic [NUM_W-1:0]  rem_reg  [QUO_W+1];
    logic [DMAG_W-1:0] dmag_reg [QUO_W+1];
    logic [QUO_W-1:0]  quo_reg  [QUO_W+1];
    logic              neg_reg  [QUO_W+1];
    logic              big_reg  [QUO_W+1];

    logic [NUM_W-1:0]  nmag;
    logic [DMAG_W-1:0] dmag;

    always_comb
    begin
        nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dmag = det[DET_W-1] ? DMAG_W'(-det) : DMAG_W'(det);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QUO_W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= QUO_W; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= nmag;
        dmag_reg[0] <= dmag;
        quo_reg[0]  <= '0;
        neg_reg[0]  <= num[NUM_W-1] ^ det[DET_W-1];
        big_reg[0]  <= CMP_W'(nmag) >= (CMP_W'(dmag) << QUO_W);
    end

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_bit
        localparam int BIT = QUO_W - 1 - j;
        logic [CMP_W-1:0] trial;
        logic             take;
        assign trial = CMP_W'(dmag_reg[j]) << BIT;
        assign take  = CMP_W'(rem_reg[j]) >= trial;
        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= take ? NUM_W'(CMP_W'(rem_reg[j]) - trial) : rem_reg[j];
            quo_reg[j+1]  <= take ? (quo_reg[j] | (QUO_W'(1) << BIT)) : quo_reg[j];
            dmag_reg[j+1] <= dmag_reg[j];
            neg_reg[j+1]  <= neg_reg[j];
            big_reg[j+1]  <= big_reg[j];
        end
    end

    assign res.valid = vld_reg[QUO_W];
    assign res.neg   = neg_reg[QUO_W];
    assign res.big   = big_reg[QUO_W];
    assign res.quo   = quo_reg[QUO_W];

endmodule

// ===== hw/rtl/rhi_project.sv =====
// ----------------------------------------------------------------------------
// rhi_project: clamp, project and saturate
// Clamps the line parameter, scales the first direction by it, adds the
// first point and saturates the coordinates into the output register.
// ----------------------------------------------------------------------------
module rhi_project
    import rhi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  div_out_t                 dres,
    input  logic signed [TRIG_W-1:0] c1,
    input  logic signed [TRIG_W-1:0] s1,
    input  logic signed [POS_W-1:0]  x1,
    input  logic signed [POS_W-1:0]  y1,
    input  logic                     parallel,
    output logic                     done,
    output logic signed [POS_W-1:0]  cross_x,
    output logic signed [POS_W-1:0]  cross_y,
    output logic [1:0]               status
);

    localparam int LO_W  = 18;
    localparam int HI_W  = QUO_W - LO_W;
    localparam int PH_W  = HI_W + TRIG_W;
    localparam int PL_W  = LO_W + 1 + TRIG_W;
    localparam int PR_W  = QUO_W + TRIG_W + 1;
    localparam int V_W   = PR_W - 28;
    localparam int SUM_W = V_W + 1;
    localparam logic signed [SUM_W-1:0] MAXV = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] MINV = SUM_W'(-64'sd2147483648);
    localparam logic [QUO_W-1:0]        LIM  = QUO_W'(S_LIMIT);

    logic                      v0_reg, v1_reg, v2_reg, done_reg;
    logic signed [QUO_W-1:0]   s0_reg;
    logic                      sat0_reg, sat1_reg, sat2_reg;
    logic                      par0_reg, par1_reg, par2_reg;
    logic signed [TRIG_W-1:0]  c0_reg, sn0_reg;
    logic signed [POS_W-1:0]   x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [PH_W-1:0]    pxh_reg, pyh_reg;
    logic signed [PL_W-1:0]    pxl_reg, pyl_reg;
    logic signed [V_W-1:0]     vx_reg, vy_reg;
    logic signed [POS_W-1:0]   cx_reg, cy_reg;
    logic [1:0]                st_reg;

    logic                      over;
    logic [QUO_W-1:0]          smag;
    logic signed [HI_W-1:0]    s_hi;
    logic signed [LO_W:0]      s_lo;
    logic signed [PR_W-1:0]    prx, pry;
    logic signed [SUM_W-1:0]   sumx, sumy;
    logic signed [POS_W-1:0]   rx, ry;
    logic                      satx, saty;
    status_t                   st_next;

    always_comb
    begin
        over = dres.big || (dres.quo > LIM);
        smag = over ? LIM : dres.quo;
    end

    always_comb
    begin
        s_hi = s0_reg[QUO_W-1:LO_W];
        s_lo = $signed({1'b0, s0_reg[LO_W-1:0]});
        prx  = (PR_W'(pxh_reg) <<< LO_W) + PR_W'(pxl_reg);
        pry  = (PR_W'(pyh_reg) <<< LO_W) + PR_W'(pyl_reg);
    end

    always_comb
    begin
        sumx = SUM_W'(x2_reg) + SUM_W'(vx_reg);
        sumy = SUM_W'(y2_reg) + SUM_W'(vy_reg);
        satx = (sumx > MAXV) || (sumx < MINV);
        saty = (sumy > MAXV) || (sumy < MINV);
        rx   = (sumx > MAXV) ? POS_W'(MAXV) : ((sumx < MINV) ? POS_W'(MINV) : POS_W'(sumx));
        ry   = (sumy > MAXV) ? POS_W'(MAXV) : ((sumy < MINV) ? POS_W'(MINV) : POS_W'(sumy));
        if (par2_reg)
        begin
            st_next = ST_PARALLEL;
        end
        else if (sat2_reg || satx || saty)
        begin
            st_next = ST_SATURATED;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= dres.valid;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg   <= dres.neg ? -$signed(smag) : $signed(smag);
        sat0_reg <= over;
        par0_reg <= parallel;
        c0_reg   <= c1;
        sn0_reg  <= s1;
        x0_reg   <= x1;
        y0_reg   <= y1;

        pxh_reg  <= PH_W'(s_hi) * PH_W'(c0_reg);
        pyh_reg  <= PH_W'(s_hi) * PH_W'(sn0_reg);
        pxl_reg  <= PL_W'(s_lo) * PL_W'(c0_reg);
        pyl_reg  <= PL_W'(s_lo) * PL_W'(sn0_reg);
        sat1_reg <= sat0_reg;
        par1_reg <= par0_reg;
        x1_reg   <= x0_reg;
        y1_reg   <= y0_reg;

        vx_reg   <= V_W'(prx >>> 28);
        vy_reg   <= V_W'(pry >>> 28);
        sat2_reg <= sat1_reg;
        par2_reg <= par1_reg;
        x2_reg   <= x1_reg;
        y2_reg   <= y1_reg;

        cx_reg   <= par2_reg ? x2_reg : rx;
        cy_reg   <= par2_reg ? y2_reg : ry;
        st_reg   <= st_next;
    end

    assign done    = done_reg;
    assign cross_x = cx_reg;
    assign cross_y = cy_reg;
    assign status  = st_reg;

endmodule

// ===== hw/rtl/ray_heading_intersection.sv =====
// ----------------------------------------------------------------------------
// ray_heading_intersection: crossing point of two point-and-heading lines
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the per-stage CORDIC iterations and the 37-stage divider.
// Reset clears only the valid bits; in-flight words are dropped.
// ----------------------------------------------------------------------------
module ray_heading_intersection
    import rhi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [POS_W-1:0]  first_x,
    input  logic signed [POS_W-1:0]  first_y,
    input  logic signed [HEAD_W-1:0] first_heading,
    input  logic signed [POS_W-1:0]  second_x,
    input  logic signed [POS_W-1:0]  second_y,
    input  logic signed [HEAD_W-1:0] second_heading,
    output logic                     done,
    output logic signed [POS_W-1:0]  cross_x,
    output logic signed [POS_W-1:0]  cross_y,
    output logic [1:0]               status
);

    localparam int MID_LAT = GEOM_LAT + DIV_LAT;

    typedef struct packed {
        logic signed [POS_W-1:0]  x1;
        logic signed [POS_W-1:0]  y1;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } entry_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  x1;
        logic signed [POS_W-1:0]  y1;
        logic signed [TRIG_W-1:0] c1;
        logic signed [TRIG_W-1:0] s1;
    } mid_t;

    entry_t                   ent_reg [SC_LAT];
    mid_t                     mid_reg [MID_LAT];
    logic                     par_reg [DIV_LAT];

    entry_t                   ent_next;
    mid_t                     mid_next;

    logic                     sc1_valid, sc2_valid;
    logic signed [TRIG_W-1:0] c1, s1, c2, s2;
    logic                     g_valid;
    logic signed [NUM_W-1:0]  g_num;
    logic signed [DET_W-1:0]  g_det;
    logic                     g_par;
    div_out_t                 dres;

    assign busy = 1'b0;

    always_comb
    begin
        ent_next.x1 = first_x;
        ent_next.y1 = first_y;
        ent_next.dx = DIFF_W'(first_x) - DIFF_W'(second_x);
        ent_next.dy = DIFF_W'(first_y) - DIFF_W'(second_y);
        mid_next.x1 = ent_reg[SC_LAT-1].x1;
        mid_next.y1 = ent_reg[SC_LAT-1].y1;
        mid_next.c1 = c1;
        mid_next.s1 = s1;
    end

    // advance side data in step with the pipeline
    always_ff @(posedge clk)
    begin
        ent_reg[0] <= ent_next;
        for (int k = 1; k < SC_LAT; k++)
        begin
            ent_reg[k] <= ent_reg[k-1];
        end
        mid_reg[0] <= mid_next;
        for (int k = 1; k < MID_LAT; k++)
        begin
            mid_reg[k] <= mid_reg[k-1];
        end
        par_reg[0] <= g_par;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            par_reg[k] <= par_reg[k-1];
        end
    end

    rhi_sincos u_sincos_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .heading   (first_heading),
        .out_valid (sc1_valid),
        .cos_q28   (c1),
        .sin_q28   (s1)
    );

    rhi_sincos u_sincos_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .heading   (second_heading),
        .out_valid (sc2_valid),
        .cos_q28   (c2),
        .sin_q28   (s2)
    );

    rhi_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc1_valid & sc2_valid),
        .c1        (c1),
        .s1        (s1),
        .c2        (c2),
        .s2        (s2),
        .dx        (ent_reg[SC_LAT-1].dx),
        .dy        (ent_reg[SC_LAT-1].dy),
        .out_valid (g_valid),
        .num       (g_num),
        .det       (g_det),
        .parallel  (g_par)
    );

    rhi_divide u_divide (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (g_valid),
        .num      (g_num),
        .det      (g_det),
        .res      (dres)
    );

    rhi_project u_project (
        .clk      (clk),
        .rst_n    (rst_n),
        .dres     (dres),
        .c1       (mid_reg[MID_LAT-1].c1),
        .s1       (mid_reg[MID_LAT-1].s1),
        .x1       (mid_reg[MID_LAT-1].x1),
        .y1       (mid_reg[MID_LAT-1].y1),
        .parallel (par_reg[DIV_LAT-1]),
        .done     (done),
        .cross_x  (cross_x),
        .cross_y  (cross_y),
        .status   (status)
    );

endmodule

// ===== tb/ray_heading_intersection_checker.sv =====
// ----------------------------------------------------------------------------
// ray_heading_intersection_checker: crossing point predictor and comparator
// Watches accepted words on the command side, predicts the crossing point
// with a CORDIC sine/cosine and exact 64-bit geometry, and compares every
// done pulse against the oldest prediction.
// ----------------------------------------------------------------------------
module ray_heading_intersection_checker
    import rhi_pkg::*;
(
    input  logic                     clk,
    input  logic                     start,
    input  logic                     busy,
    input  logic signed [POS_W-1:0]  first_x,
    input  logic signed [POS_W-1:0]  first_y,
    input  logic signed [HEAD_W-1:0] first_heading,
    input  logic signed [POS_W-1:0]  second_x,
    input  logic signed [POS_W-1:0]  second_y,
    input  logic signed [HEAD_W-1:0] second_heading,
    input  logic                     done,
    input  logic signed [POS_W-1:0]  cross_x,
    input  logic signed [POS_W-1:0]  cross_y,
    input  logic [1:0]               status,
    output int                       fail_count,
    output int                       pending
);

    typedef struct {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        status_t                 st;
    } crossing_t;

    crossing_t crossings_due[$];

    localparam longint ATAN_TBL [31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097151,
        1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    initial fail_count = 0;
    assign pending = crossings_due.size();

    task automatic report(input string what, input longint got, input longint want);
        fail_count++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic heading_trig(input logic signed [HEAD_W-1:0] h,
                                output longint c, output longint s);
        longint r, x, y, z, xs, ys;
        bit flip;
        r = (longint'(h) * (longint'(1) << (30 - FRAC_BITS))) % TWO_PI_Q30;
        flip = 0;
        if (r < 0) r += TWO_PI_Q30;
        if (r > PI_Q30) r -= TWO_PI_Q30;
        if (r > HALF_PI_Q30)
        begin
            r -= PI_Q30;
            flip = 1;
        end
        else if (r < -HALF_PI_Q30)
        begin
            r += PI_Q30;
            flip = 1;
        end
        x = CORDIC_K;
        y = 0;
        z = r;
        for (int i = 0; i < CORDIC_STEPS && i < 31; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= ATAN_TBL[i];
            end
            else
            begin
                x += ys; y -= xs; z += ATAN_TBL[i];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = x >>> 2;
        s = y >>> 2;
    endtask

    function automatic logic signed [POS_W-1:0] clamp32(input longint v, inout bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    task automatic predict_crossing();
        longint c1, s1, c2, s2, det, dx, dy, num, sp;
        bit sat;
        crossing_t e;
        heading_trig(first_heading, c1, s1);
        heading_trig(second_heading, c2, s2);
        det = (s1 * c2 - c1 * s2) >>> 28;
        sat = 0;
        if (det == 0)
        begin
            e.px = first_x;
            e.py = first_y;
            e.st = ST_PARALLEL;
        end
        else
        begin
            dx = longint'(first_x) - longint'(second_x);
            dy = longint'(first_y) - longint'(second_y);
            num = dx * s2 - dy * c2;
            sp = num / det;
            if (sp > S_LIMIT)
            begin
                sp = S_LIMIT; sat = 1;
            end
            else if (sp < -S_LIMIT)
            begin
                sp = -S_LIMIT; sat = 1;
            end
            e.px = clamp32(longint'(first_x) + ((sp * c1) >>> 28), sat);
            e.py = clamp32(longint'(first_y) + ((sp * s1) >>> 28), sat);
            e.st = sat ? ST_SATURATED : ST_OK;
        end
        crossings_due.push_back(e);
    endtask

    always @(posedge clk)
    begin
        crossing_t e;
        if (done)
        begin
            if (crossings_due.size() == 0)
            begin
                report("unexpected word", 0, 0);
            end
            else
            begin
                e = crossings_due.pop_front();
                if (cross_x !== e.px) report("cross_x", cross_x, e.px);
                if (cross_y !== e.py) report("cross_y", cross_y, e.py);
                if (status !== e.st) report("status", status, e.st);
            end
        end
        if (start && !busy)
            predict_crossing();
    end

endmodule

// ===== tb/ray_heading_intersection_tb.sv =====
// ----------------------------------------------------------------------------
// ray_heading_intersection_tb: line crossing regression
// Drives directed and random line pairs with random sender gaps through three
// pressure phases, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module ray_heading_intersection_tb;
    import rhi_pkg::*;

    localparam int WATCHDOG = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy, done;
    logic signed [POS_W-1:0]  first_x = 0, first_y = 0, second_x = 0, second_y = 0;
    logic signed [HEAD_W-1:0] first_heading = 0, second_heading = 0;
    logic signed [POS_W-1:0]  cross_x, cross_y;
    logic [1:0] status;
    int fail_count, pending;
    int quiet_cycles = 0;

    always #1 clk = ~clk;

    ray_heading_intersection dut (.*);
    ray_heading_intersection_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [POS_W-1:0] pick_pos();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom());
            default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
        endcase
    endfunction

    function automatic logic signed [HEAD_W-1:0] pick_heading();
        case ($urandom_range(0, 4))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            default: return HEAD_W'($urandom());
        endcase
    endfunction

    task automatic send_word(input logic signed [POS_W-1:0] ax, ay,
                             input logic signed [HEAD_W-1:0] ah,
                             input logic signed [POS_W-1:0] bx, by,
                             input logic signed [HEAD_W-1:0] bh, input int gap_pct);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 0;
            @(negedge clk);
        end
        start <= 1;
        first_x <= ax; first_y <= ay; first_heading <= ah;
        second_x <= bx; second_y <= by; second_heading <= bh;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic signed [HEAD_W-1:0] h;
        int gap_pct;
        repeat (2) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        send_word(0, 0, 0, 32'sh10000, 0, 24'sh019220, 0);
        send_word(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 24'sh019220, 0);
        send_word(32'sh80000000, 32'sh7fffffff, 24'sh7fffff, 0, 0, 24'sh800000, 0);
        send_word(0, 0, 24'sh010000, 32'sh50000, 32'sh50000, 24'sh010000, 0);
        send_word(0, 0, 0, 32'sh10000, 32'sh10000, 24'sh03243f, 0);
        send_word(0, 0, 0, 32'sh10000, 32'sh10000, 24'sh000001, 0);
        send_word(32'sh7fff0000, 0, 24'sh00c910, 0, 0, 24'sh000010, 0);
        send_word(32'shffffffff, 32'sh00000001, 24'shfcdbc1, 32'sh10000, 0, 24'sh019220, 0);
        send_word(0, 0, 24'sh064880, 32'sh100000, 32'shfff00000, 24'shfe6de0, 0);
        send_word(32'sh12345678, 32'shedcba987, 24'sh0c90fe, 0, 0, 24'sh7ffff0, 0);
        send_word(0, 0, 24'sh800000, 32'sh20000, 32'sh20000, 24'sh800000, 0);
        send_word(32'sh80000000, 32'sh80000000, 24'sh01921f, 32'sh7fffffff, 32'sh7fffffff, 0, 0);

        for (int n = 0; n < 2000; n++)
        begin
            gap_pct = (n < 700) ? 15 : (n < 1400) ? 74 : 0;
            h = pick_heading();
            if ($urandom_range(0, 9) == 0)
                send_word(pick_pos(), pick_pos(), h, pick_pos(), pick_pos(),
                          h + $signed(24'($urandom_range(0, 4))) - 24'sd2, gap_pct);
            else
                send_word(pick_pos(), pick_pos(), h, pick_pos(), pick_pos(),
                          pick_heading(), gap_pct);
        end
        start <= 0;

        while (pending != 0) @(posedge clk);
        repeat (CORDIC_STEPS + 60) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== ray_heading_intersection.f =====
hw/rtl/rhi_pkg.sv
hw/rtl/rhi_sincos.sv
hw/rtl/rhi_geom.sv
hw/rtl/rhi_divide.sv
hw/rtl/rhi_project.sv
hw/rtl/ray_heading_intersection.sv
tb/ray_heading_intersection_checker.sv
tb/ray_heading_intersection_tb.sv
